// ===== rtl/core/bqd_pkg.sv =====
package bqd_pkg;

  // Fixed formats: coefficients are Q2.16, the gain is Q8.16.
  localparam int COEF_W       = 18;
  localparam int GAIN_W       = 24;
  localparam int FRAC_W       = 16;
  localparam int SAMPLE_W_DEF = 16;

  // Feed-forward taps and feedback taps of one second-order section.
  localparam int SECTION_TAPS = 3;
  localparam int FB_TAPS      = 2;

  // Running sum of a serial dot product; three taps of COEF_W bits need three guard bits.
  localparam int DOT_ACC_W = COEF_W + 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;

  // Reset values: unity feed-forward tap and unity gain, all else zero.
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

  // Controls for one step of a bit-serial dot product.
  typedef struct packed {
    logic clr;  // zero the running sum before the first bit
    logic en;   // take one bit of every sample this cycle
    logic neg;  // this bit is the sign bit, so its partial sum is subtracted
  } bqd_step_t;

endpackage

// ===== rtl/core/bqd_dot_serial.sv =====
module bqd_dot_serial #(
  parameter int TAPS = bqd_pkg::SECTION_TAPS,
  parameter int SW   = bqd_pkg::SAMPLE_W_DEF
) (
  input  logic                                     clk,
  input  bqd_pkg::bqd_step_t                       ctl,
  input  logic [TAPS-1:0][bqd_pkg::COEF_W-1:0]     coef,
  input  logic [TAPS-1:0]                          bits,
  output logic [bqd_pkg::DOT_ACC_W-1:0]            acc,
  output logic [SW-1:0]                            lo
);
  import bqd_pkg::*;

  // Serial-parallel multiply-accumulate: one bit of every sample per enabled cycle,
  // LSB first. The result is {acc, lo}, a signed value of DOT_ACC_W + SW bits.
  logic [DOT_ACC_W-1:0] acc_r;
  logic [SW-1:0]        lo_r;
  logic [DOT_ACC_W-1:0] pp;
  logic [DOT_ACC_W-1:0] sum;

  always_comb begin
    pp = '0;
    for (int k = 0; k < TAPS; k++) begin
      if (bits[k]) begin
        pp = pp + {{(DOT_ACC_W-COEF_W){coef[k][COEF_W-1]}}, coef[k]};
      end
    end
    sum = acc_r + (ctl.neg ? -pp : pp);
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.en) begin
      acc_r <= {sum[DOT_ACC_W-1], sum[DOT_ACC_W-1:1]};
      lo_r  <= {sum[0], lo_r[SW-1:1]};
    end
  end

  assign acc = acc_r;
  assign lo  = lo_r;

endmodule

// ===== rtl/core/biquad_iir_section.sv =====
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  in_mode, in_sample
// out       source     out_valid/out_stall  out_filtered, out_saturated
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// From acceptance to the next acceptance, a filter request runs the bit-serial dot
// products, then the gain multiply at one gain bit a cycle, loads the output once the
// output register is free, and goes back to idle. A clear request goes straight from
// idle to the output state. Reset is synchronous and active low; it clears the
// histories and loads the default coefficients. A stalled result waits in the output
// register while the next request is already taken and worked on.
module biquad_iir_section #(
  parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_filtered,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [bqd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bqd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bqd_pkg::*;

  localparam int SW       = SAMPLE_WIDTH;
  localparam int STEP_MAX = (SW > GAIN_W) ? SW : GAIN_W;
  localparam int CNT_W    = $clog2(STEP_MAX);
  // Full-precision feed-forward and feedback sums.
  localparam int FF_W     = DOT_ACC_W + SW;
  // Gain accumulator: the gain product plus the feedback term, with guard bits.
  localparam int ACC2_W   = FF_W + 3;
  // The output before saturation is the accumulator without its 8 low bits.
  localparam int YF_W     = ACC2_W - (2 * FRAC_W - GAIN_W);
  localparam logic [ACC2_W-1:0] RND_HALF = ACC2_W'(1) << (FRAC_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DOT  = 4'b0010,
    ST_GAIN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Configuration registers.
  logic [COEF_W-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= COEF_ONE;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
      gain_r    <= GAIN_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:   coef_b0_r <= cfg_data[COEF_W-1:0];
        REG_B1:   coef_b1_r <= cfg_data[COEF_W-1:0];
        REG_B2:   coef_b2_r <= cfg_data[COEF_W-1:0];
        REG_A1:   coef_a1_r <= cfg_data[COEF_W-1:0];
        REG_A2:   coef_a2_r <= cfg_data[COEF_W-1:0];
        REG_GAIN: gain_r    <= cfg_data[GAIN_W-1:0];
        default:  ;
      endcase
    end
  end

  // Sequencer and datapath registers. The sample and the four histories are
  // rotated one bit per cycle during the dot-product phase; by the end of that
  // phase they hold their original values again.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              clr_r, clr_nxt;
  logic [SW-1:0]     x_r, x_nxt;
  logic [SW-1:0]     x1_r, x1_nxt, x2_r, x2_nxt;
  logic [SW-1:0]     y1_r, y1_nxt, y2_r, y2_nxt;
  logic [GAIN_W-1:0] gsh_r, gsh_nxt;
  logic [ACC2_W-1:0] acc2_r, acc2_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     out_filtered_r, out_filtered_nxt;
  logic              out_saturated_r, out_saturated_nxt;

  logic accept;
  logic out_free;
  logic dot_last;
  logic gain_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign dot_last  = (cnt_r == CNT_W'(SW - 1));
  assign gain_last = (cnt_r == CNT_W'(GAIN_W - 1));

  // Two serial dot products run side by side: b0*x + b1*x1 + b2*x2 and a1*y1 + a2*y2.
  bqd_step_t                               dot_ctl;
  logic [SECTION_TAPS-1:0][COEF_W-1:0]     ff_coef;
  logic [FB_TAPS-1:0][COEF_W-1:0]          fb_coef;
  logic [DOT_ACC_W-1:0]                    ff_acc, fb_acc;
  logic [SW-1:0]                           ff_lo, fb_lo;

  assign dot_ctl.clr = accept;
  assign dot_ctl.en  = (state_r == ST_DOT);
  assign dot_ctl.neg = dot_last;
  assign ff_coef     = {coef_b2_r, coef_b1_r, coef_b0_r};
  assign fb_coef     = {coef_a2_r, coef_a1_r};

  bqd_dot_serial #(
    .TAPS (SECTION_TAPS),
    .SW   (SW)
  ) u_ff (
    .clk  (clk),
    .ctl  (dot_ctl),
    .coef (ff_coef),
    .bits ({x2_r[0], x1_r[0], x_r[0]}),
    .acc  (ff_acc),
    .lo   (ff_lo)
  );

  bqd_dot_serial #(
    .TAPS (FB_TAPS),
    .SW   (SW)
  ) u_fb (
    .clk  (clk),
    .ctl  (dot_ctl),
    .coef (fb_coef),
    .bits ({y2_r[0], y1_r[0]}),
    .acc  (fb_acc),
    .lo   (fb_lo)
  );

  // Gain phase: ff times the gain, one gain bit per cycle, LSB first, with a
  // right-shifting accumulator. At gain bit 16 the accumulator carries weight
  // 2^16, which is where the feedback sum and the rounding half (2^31 overall)
  // go in. After all 24 bits the shifted-out bits lie below 2^24, so the rounded
  // output is simply the accumulator without its 8 low bits.
  logic [FF_W-1:0]   ff_full, fb_full;
  logic [ACC2_W-1:0] ff_ext, fb_ext, pp, inj, sum2;

  assign ff_full = {ff_acc, ff_lo};
  assign fb_full = {fb_acc, fb_lo};
  assign ff_ext  = {{(ACC2_W-FF_W){ff_full[FF_W-1]}}, ff_full};
  assign fb_ext  = {{(ACC2_W-FF_W){fb_full[FF_W-1]}}, fb_full};
  assign pp      = gsh_r[0] ? ff_ext : '0;
  assign inj     = (cnt_r == CNT_W'(FRAC_W)) ? (RND_HALF - fb_ext) : '0;
  assign sum2    = acc2_r + (gain_last ? -pp : pp) + inj;

  // Saturation of the finished output to the sample range.
  logic [YF_W-1:0] y_full;
  logic            y_in_range;
  logic [SW-1:0]   y_sat;

  assign y_full     = acc2_r[ACC2_W-1:ACC2_W-YF_W];
  assign y_in_range = (&y_full[YF_W-1:SW-1]) || !(|y_full[YF_W-1:SW-1]);

  always_comb begin
    if (y_in_range) begin
      y_sat = y_full[SW-1:0];
    end else if (y_full[YF_W-1]) begin
      y_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    clr_nxt           = clr_r;
    x_nxt             = x_r;
    x1_nxt            = x1_r;
    x2_nxt            = x2_r;
    y1_nxt            = y1_r;
    y2_nxt            = y2_r;
    gsh_nxt           = gsh_r;
    acc2_nxt          = acc2_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_filtered_nxt  = out_filtered_r;
    out_saturated_nxt = out_saturated_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt     = in_sample;
          clr_nxt   = in_mode;
          cnt_nxt   = '0;
          // A clear request skips the arithmetic and goes straight to the output.
          state_nxt = in_mode ? ST_OUT : ST_DOT;
        end
      end
      ST_DOT: begin
        x_nxt  = {x_r[0], x_r[SW-1:1]};
        x1_nxt = {x1_r[0], x1_r[SW-1:1]};
        x2_nxt = {x2_r[0], x2_r[SW-1:1]};
        y1_nxt = {y1_r[0], y1_r[SW-1:1]};
        y2_nxt = {y2_r[0], y2_r[SW-1:1]};
        if (dot_last) begin
          cnt_nxt   = '0;
          gsh_nxt   = gain_r;
          acc2_nxt  = '0;
          state_nxt = ST_GAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_GAIN: begin
        acc2_nxt = {sum2[ACC2_W-1], sum2[ACC2_W-1:1]};
        gsh_nxt  = {1'b0, gsh_r[GAIN_W-1:1]};
        if (gain_last) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (clr_r) begin
            out_filtered_nxt  = '0;
            out_saturated_nxt = 1'b0;
            x1_nxt            = '0;
            x2_nxt            = '0;
            y1_nxt            = '0;
            y2_nxt            = '0;
          end else begin
            // The saturated output is what enters the feedback history.
            out_filtered_nxt  = y_sat;
            out_saturated_nxt = !y_in_range;
            x2_nxt            = x1_r;
            x1_nxt            = x_r;
            y2_nxt            = y1_r;
            y1_nxt            = y_sat;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      clr_r       <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r             <= x_nxt;
    gsh_r           <= gsh_nxt;
    acc2_r          <= acc2_nxt;
    out_filtered_r  <= out_filtered_nxt;
    out_saturated_r <= out_saturated_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = out_filtered_r;
  assign out_saturated = out_saturated_r;

endmodule

// ===== sim/tb_biquad_iir_section.sv =====
`timescale 1ns / 1ps

module tb_biquad_iir_section;
  import bqd_pkg::*;

  localparam int SW = SAMPLE_W_DEF;

  // The run stops here even if the block hangs. The slowest correct run is about
  // 1800 requests plus sender gaps and receiver stalls, well under a quarter of this.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Cycles to let pass once the last result is in before a register write or the
  // end of the run.
  localparam int SETTLE_CYCLES = 60;

  // Requests in each random phase, and how many random phases there are.
  localparam int PHASE_REQUESTS = 290;
  localparam int PHASE_COUNT = 6;

  // Indexes past the end of the register list. Writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // These are the two request modes.
  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Kinds of coefficient set that the random phases load.
  localparam int SET_STABLE = 0;
  localparam int SET_ANY = 1;
  localparam int SET_CORNER = 2;

  localparam longint Y_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) <<< (SW - 1));

  typedef struct packed {
    logic mode;
    logic [SW-1:0] sample;
  } sample_req_t;

  typedef struct packed {
    logic signed [SW-1:0] filtered;
    logic saturated;
  } filt_out_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_mode;
  logic signed [SW-1:0] in_sample;
  logic out_valid;
  logic out_stall;
  logic signed [SW-1:0] out_filtered;
  logic out_saturated;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  biquad_iir_section #(
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_filtered(out_filtered),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The clock runs with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Requests not yet offered to the block, and the outputs that the accepted
  // requests should produce, oldest first.
  sample_req_t sample_q[$];
  filt_out_t filtered_q[$];

  // Our own copy of the register file and of the four history registers.
  logic signed [COEF_W-1:0] tap_coef[0:4];
  logic signed [GAIN_W-1:0] ff_gain;
  logic signed [SW-1:0] hist_x1, hist_x2, hist_y1, hist_y2;

  // Knobs that the sequence in the initial block turns.
  int in_idle_pct;
  int out_idle_pct;
  bit hold_sender;

  // Set by the monitor when the block takes a request, cleared by the driver.
  bit req_taken;

  int n_errors;
  int n_accepted;
  int n_filtered;
  int n_cleared;
  int n_clipped;
  int n_settings;
  int cycle_count;

  // One filter step. A clear zeroes every history and reads as a zero output.
  // Otherwise the whole sum is formed at scale 2^-32, half an output LSB is added
  // and the arithmetic shift floors it, which rounds ties toward plus infinity.
  // The clipped value is what goes back into the output history.
  function automatic void biquad_step(input logic mode, input logic signed [SW-1:0] x,
                                      output filt_out_t res);
    longint ff;
    longint fb;
    longint acc;
    longint yv;
    res.saturated = 1'b0;
    res.filtered = '0;
    if (mode == MODE_CLEAR) begin
      hist_x1 = '0;
      hist_x2 = '0;
      hist_y1 = '0;
      hist_y2 = '0;
    end else begin
      ff = longint'(tap_coef[REG_B0]) * longint'(x)
         + longint'(tap_coef[REG_B1]) * longint'(hist_x1)
         + longint'(tap_coef[REG_B2]) * longint'(hist_x2);
      fb = longint'(tap_coef[REG_A1]) * longint'(hist_y1)
         + longint'(tap_coef[REG_A2]) * longint'(hist_y2);
      acc = ff * longint'(ff_gain) - (fb <<< FRAC_W) + (longint'(1) <<< (2 * FRAC_W - 1));
      yv = acc >>> (2 * FRAC_W);
      if (yv > Y_MAX) begin
        yv = Y_MAX;
        res.saturated = 1'b1;
      end else if (yv < Y_MIN) begin
        yv = Y_MIN;
        res.saturated = 1'b1;
      end
      res.filtered = SW'(yv);
      hist_x2 = hist_x1;
      hist_x1 = x;
      hist_y2 = hist_y1;
      hist_y1 = res.filtered;
    end
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Monitor: both handshakes are looked at on the rising edge, before the block's
  // own registers move. Every accepted request gets its expected output worked out
  // right away; the configuration cannot change while requests are in flight.
  always @(posedge clk) begin
    filt_out_t pred;
    filt_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        biquad_step(in_mode, in_sample, pred);
        filtered_q.push_back(pred);
        req_taken = 1'b1;
        n_accepted++;
        if (in_mode == MODE_CLEAR) begin
          n_cleared++;
        end else begin
          n_filtered++;
        end
        if (pred.saturated) begin
          n_clipped++;
        end
      end
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          flag_error($sformatf("output %0d sat %0b with no request pending",
                               out_filtered, out_saturated));
        end else begin
          want = filtered_q.pop_front();
          if (out_filtered !== want.filtered || out_saturated !== want.saturated) begin
            flag_error($sformatf("filtered exp %0d got %0d, saturated exp %0b got %0b",
                                 want.filtered, out_filtered, want.saturated,
                                 out_saturated));
          end
        end
      end
    end
  end

  // Driver: inputs move on the falling edge. A new request is only loaded once the
  // previous one was taken, so a stalled request holds still. While the sender
  // idles the payload wanders at random to show that it is ignored.
  always @(negedge clk) begin
    sample_req_t nxt;
    out_stall <= ($urandom_range(99) < out_idle_pct);
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (!hold_sender && sample_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = sample_q.pop_front();
        in_valid <= 1'b1;
        in_mode <= nxt.mode;
        in_sample <= nxt.sample;
      end else begin
        in_valid <= 1'b0;
        in_mode <= 1'($urandom);
        in_sample <= SW'($urandom);
      end
    end
  end

  // The watchdog ends a run that goes on too long.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               filtered_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // One register write, mirrored into our copy. Bits above a register's width are
  // dropped, and an index past the list changes nothing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: tap_coef[idx] = data[COEF_W-1:0];
      REG_GAIN: ff_gain = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_coefs(input int b0, input int b1, input int b2, input int a1,
                             input int a2, input int g);
    write_reg(REG_B0, {6'($urandom), COEF_W'(b0)});
    write_reg(REG_B1, {6'($urandom), COEF_W'(b1)});
    write_reg(REG_B2, {6'($urandom), COEF_W'(b2)});
    write_reg(REG_A1, {6'($urandom), COEF_W'(a1)});
    write_reg(REG_A2, {6'($urandom), COEF_W'(a2)});
    write_reg(REG_GAIN, GAIN_W'(g));
    n_settings++;
  endtask

  function automatic int corner_coef();
    case ($urandom_range(5))
      0: return -131072;
      1: return 131071;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return 65536;
    endcase
  endfunction

  function automatic int corner_gain();
    case ($urandom_range(5))
      0: return -8388608;
      1: return 8388607;
      2: return 65536;
      3: return -65536;
      4: return 0;
      default: return 1;
    endcase
  endfunction

  // Load a coefficient set. Stable sets keep the poles inside the unit circle
  // (|a2| < 1 and |a1| < 1 + a2) so the output keeps tracking the input instead of
  // pinning at a rail; the other kinds go after clipping and the corners of the
  // multiplier.
  task automatic load_coefs(input int kind);
    int a1;
    int a2;
    int lim;
    case (kind)
      SET_STABLE: begin
        a2 = int'($urandom_range(98304)) - 49152;
        lim = 65536 + a2 - 1024;
        a1 = int'($urandom_range(2 * lim)) - lim;
        write_coefs(int'($urandom_range(65536)) - 32768, int'($urandom_range(65536)) - 32768,
                    int'($urandom_range(65536)) - 32768, a1, a2,
                    int'($urandom_range(262144)) - 131072);
      end
      SET_ANY: begin
        write_coefs(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom));
      end
      SET_CORNER: begin
        write_coefs(corner_coef(), corner_coef(), corner_coef(), corner_coef(),
                    corner_coef(), corner_gain());
      end
      default: ;
    endcase
  endtask

  function automatic void queue_sample(input logic mode, input int sample);
    sample_req_t r;
    r.mode = mode;
    r.sample = SW'(sample);
    sample_q.push_back(r);
  endfunction

  // Mostly filter requests with a sprinkling of clears. Samples are a mix of full
  // range, small values near zero and the two rails.
  function automatic void queue_random_sample();
    int s;
    case ($urandom_range(9))
      0: s = $urandom_range(1) ? 32767 : -32768;
      1, 2, 3: s = int'($urandom_range(512)) - 256;
      default: s = int'(SW'($urandom));
    endcase
    queue_sample(($urandom_range(99) < 4) ? MODE_CLEAR : MODE_FILTER, s);
  endfunction

  // Let everything queued go through, every result come back, and the block settle.
  task automatic wait_idle();
    while (!(sample_q.size() == 0 && !in_valid && filtered_q.size() == 0)) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_FILTER;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_sender = 1'b0;
    req_taken = 1'b0;
    n_errors = 0;
    n_accepted = 0;
    n_filtered = 0;
    n_cleared = 0;
    n_clipped = 0;
    n_settings = 1;
    cycle_count = 0;
    in_idle_pct = 35;
    out_idle_pct = 70;

    // Reset state: unity b0 and unity gain, everything else zero.
    tap_coef[REG_B0] = COEF_ONE;
    tap_coef[REG_B1] = '0;
    tap_coef[REG_B2] = '0;
    tap_coef[REG_A1] = '0;
    tap_coef[REG_A2] = '0;
    ff_gain = GAIN_ONE;
    hist_x1 = '0;
    hist_x2 = '0;
    hist_y1 = '0;
    hist_y2 = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes past the register list must leave the defaults alone, which the pass
    // through with unity gain below then shows.
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));

    // Defaults: the output equals the input. Rails, the alternating bit patterns,
    // a clear in the middle of a run, and a clear whose sample is nonzero.
    queue_sample(MODE_FILTER, 32767);
    queue_sample(MODE_FILTER, -32768);
    queue_sample(MODE_FILTER, 0);
    queue_sample(MODE_FILTER, -1);
    queue_sample(MODE_FILTER, 1);
    queue_sample(MODE_FILTER, 16'h5555);
    queue_sample(MODE_FILTER, -21846);
    queue_sample(MODE_CLEAR, 12345);
    queue_sample(MODE_FILTER, 100);
    queue_sample(MODE_CLEAR, -32768);
    wait_idle();

    // Every register at an extreme: both rails get hit, and the clipped value
    // feeds back through the largest coefficients.
    write_coefs(131071, -131072, 131071, -131072, 131071, 8388607);
    queue_sample(MODE_FILTER, 32767);
    queue_sample(MODE_FILTER, -32768);
    queue_sample(MODE_FILTER, 1000);
    queue_sample(MODE_FILTER, -1);
    queue_sample(MODE_CLEAR, 0);
    queue_sample(MODE_FILTER, 1);
    wait_idle();

    write_coefs(-131072, 131071, -131072, 131071, -131072, -8388608);
    queue_sample(MODE_FILTER, -32768);
    queue_sample(MODE_FILTER, 32767);
    queue_sample(MODE_FILTER, 0);
    queue_sample(MODE_FILTER, 5);
    wait_idle();

    // Random phases. The two idle profiles swap halfway through the first four
    // phases, and the last two run with no idling at all.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 2) begin
        in_idle_pct = 35;
        out_idle_pct = 70;
      end else if (p < 4) begin
        in_idle_pct = 70;
        out_idle_pct = 35;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      load_coefs(p % 3);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        queue_random_sample();
      end
      if (p == 3) begin
        // Partway in, the sender holds off until the block has handed back every
        // result, then picks up where it left off with the histories intact.
        base = n_accepted;
        while (n_accepted < base + 120) begin
          @(posedge clk);
        end
        hold_sender = 1'b1;
        while (!(!in_valid && filtered_q.size() == 0)) begin
          @(posedge clk);
        end
        repeat (30) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_idle();
    end

    $display("Covered %0d filter requests and %0d clears over %0d coefficient sets.",
             n_filtered, n_cleared, n_settings);
    $display("%0d outputs were clipped; %0d errors were found.", n_clipped, n_errors);
    if (n_errors == 0 && filtered_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bqd_pkg.sv
rtl/core/bqd_dot_serial.sv
rtl/core/biquad_iir_section.sv
sim/tb_biquad_iir_section.sv
